### design/serial_register_bus_master_macros.svh
//------------------------------------------------------------------------------
// Serial register bus master assertion macros
// Concurrent assertion wrappers; empty for synthesis.
//------------------------------------------------------------------------------
`ifndef SERIAL_REGISTER_BUS_MASTER_MACROS_SVH
`define SERIAL_REGISTER_BUS_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// check a property while reset is low
`define SBM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every clock edge, reset included
`define SBM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBM_ASSERT(label, clk, rst, prop, msg)
`define SBM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/sbm_pkg.sv
//------------------------------------------------------------------------------
// Serial register bus master package
// Shared types, register indexes and reset values.
//------------------------------------------------------------------------------
package sbm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int GAP_W       = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_INCREMENT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_HALF_PERIOD    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_WORD_GAP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_WORD_GAP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELECT_RELEASE_GAP = 3'd4;

   localparam logic             RST_AUTO_INCREMENT     = 1'b1;
   localparam logic [7:0]       RST_BIT_HALF_PERIOD    = 8'd1;
   localparam logic [GAP_W-1:0] RST_WRITE_WORD_GAP     = 10'd100;
   localparam logic [GAP_W-1:0] RST_READ_WORD_GAP      = 10'd200;
   localparam logic [GAP_W-1:0] RST_SELECT_RELEASE_GAP = 10'd10;

   localparam int ADDR_W     = 12;
   localparam int FIELD_W    = 16;
   localparam int BIT_IDX_W  = 4;

   typedef struct packed {
      logic             auto_increment;
      logic [7:0]       bit_half_period;
      logic [GAP_W-1:0] write_word_gap;
      logic [GAP_W-1:0] read_word_gap;
      logic [GAP_W-1:0] select_release_gap;
   } sbm_cfg_type;

   typedef struct packed {
      logic load_item;
      logic load_data;
      logic shift_slot;
   } sbm_cmd_type;

   typedef struct packed {
      logic burst_open;
      logic is_read;
      logic cmd_phase;
      logic slot_end;
   } sbm_status_type;

endpackage

### design/sbm_csr.sv
//------------------------------------------------------------------------------
// Serial register bus master configuration registers
// Holds the increment flag and the timing registers.
//------------------------------------------------------------------------------
module sbm_csr
   import sbm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output sbm_cfg_type            cfg
);

   sbm_cfg_type cfg_ff;
   sbm_cfg_type cfg_in;

   assign csr_ready = !reset;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_AUTO_INCREMENT:     cfg_in.auto_increment     = csr_data[0];
            CSR_BIT_HALF_PERIOD:    cfg_in.bit_half_period    = csr_data[7:0];
            CSR_WRITE_WORD_GAP:     cfg_in.write_word_gap     = csr_data;
            CSR_READ_WORD_GAP:      cfg_in.read_word_gap      = csr_data;
            CSR_SELECT_RELEASE_GAP: cfg_in.select_release_gap = csr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_increment     <= RST_AUTO_INCREMENT;
         cfg_ff.bit_half_period    <= RST_BIT_HALF_PERIOD;
         cfg_ff.write_word_gap     <= RST_WRITE_WORD_GAP;
         cfg_ff.read_word_gap      <= RST_READ_WORD_GAP;
         cfg_ff.select_release_gap <= RST_SELECT_RELEASE_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/sbm_ctrl.sv
//------------------------------------------------------------------------------
// Serial register bus master controller
// Sequences word loads, serial clock slots, result handoff and gaps.
//------------------------------------------------------------------------------
`include "serial_register_bus_master_macros.svh"

module sbm_ctrl
   import sbm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  sbm_cfg_type    cfg,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  sbm_status_type status,
   output sbm_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TICK = 3'd1;
   localparam logic [2:0] S_SLOT = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;
   localparam logic [2:0] S_GAP  = 3'd4;

   logic [2:0]       state_ff;
   logic [2:0]       state_in;
   logic [GAP_W-1:0] timer_ff;
   logic [GAP_W-1:0] timer_in;
   logic [GAP_W-1:0] period;

   assign period     = GAP_W'({cfg.bit_half_period, 1'b0});
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = (state_ff == S_EMIT);

   always_comb begin
      state_in = state_ff;
      timer_in = timer_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load_item = 1'b1;
               timer_in      = period;
               state_in      = S_TICK;
            end
         end
         S_TICK: begin
            if (timer_ff <= GAP_W'(1)) begin
               state_in = S_SLOT;
            end else begin
               timer_in = timer_ff - GAP_W'(1);
            end
         end
         S_SLOT: begin
            cmd.shift_slot = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               if (!status.slot_end) begin
                  timer_in = period;
                  state_in = S_TICK;
               end else if (status.cmd_phase) begin
                  cmd.load_data = 1'b1;
                  timer_in      = period;
                  state_in      = S_TICK;
               end else begin
                  state_in = S_GAP;
                  if (!status.burst_open) begin
                     timer_in = cfg.select_release_gap;
                  end else if (status.is_read) begin
                     timer_in = cfg.read_word_gap;
                  end else begin
                     timer_in = cfg.write_word_gap;
                  end
               end
            end
         end
         S_GAP: begin
            if (timer_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               timer_in = timer_ff - GAP_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         timer_ff <= '0;
      end else begin
         state_ff <= state_in;
         timer_ff <= timer_in;
      end
   end

   `SBM_ASSERT(a_no_accept_while_result, clock, reset, !(req_tready && rsp_tvalid), "accept while result pending")
   `SBM_ASSERT_ALWAYS(a_reset_to_idle, clock, reset |=> (state_ff == S_IDLE), "not idle after reset")
   `SBM_ASSERT(a_gap_after_data_word, clock, reset, ((state_ff == S_GAP) && ($past(state_ff) != S_GAP)) |-> $past(status.slot_end && !status.cmd_phase), "gap not after data word")

endmodule

### design/sbm_dp.sv
//------------------------------------------------------------------------------
// Serial register bus master datapath
// Burst state, shift registers and the registered result word.
//------------------------------------------------------------------------------
`include "serial_register_bus_master_macros.svh"

module sbm_dp
   import sbm_pkg::*;
#(
   parameter int WORD_BITS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  sbm_cfg_type          cfg,
   input  sbm_cmd_type          cmd,
   output sbm_status_type       status,
   input  logic                 req_is_read,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [FIELD_W-1:0]   req_write_data,
   input  logic [FIELD_W-1:0]   req_line_in_word,
   input  logic                 req_last_word,
   output logic                 rsp_sdout_bit,
   output logic                 rsp_command_phase,
   output logic [BIT_IDX_W-1:0] rsp_bit_index,
   output logic                 rsp_word_done,
   output logic [FIELD_W-1:0]   rsp_read_word,
   output logic                 rsp_burst_end,
   output logic                 rsp_last
);

   localparam int CNT_W  = $clog2(WORD_BITS);
   localparam int ABITS  = ((WORD_BITS - 4) < ADDR_W) ? (WORD_BITS - 4) : ADDR_W;
   localparam logic [CNT_W-1:0]     CNT_MAX   = CNT_W'(WORD_BITS - 1);
   localparam logic [WORD_BITS-1:0] ADDR_MASK = WORD_BITS'((64'd1 << ABITS) - 64'd1);

   logic                 open_ff, open_in;
   logic                 is_read_ff, is_read_in;
   logic                 phase_ff, phase_in;
   logic                 level_ff, level_in;
   logic                 slot_end_ff, slot_end_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] out_ff, out_in;
   logic [WORD_BITS-1:0] in_ff, in_in;
   logic [WORD_BITS-1:0] line_ff, line_in;
   logic [WORD_BITS-1:0] wdata_ff, wdata_in;
   logic                 last_ff, last_in;

   logic                 sd_ff, sd_in;
   logic                 cph_ff, cph_in;
   logic [BIT_IDX_W-1:0] idx_ff, idx_in;
   logic                 done_ff, done_in;
   logic [FIELD_W-1:0]   rword_ff, rword_in;
   logic                 bend_ff, bend_in;
   logic                 lst_ff, lst_in;

   logic [WORD_BITS-1:0] command;
   logic [WORD_BITS-1:0] in_next;
   logic                 drive;
   logic                 sd;
   logic                 done;

   always_comb begin
      command              = WORD_BITS'(req_address) & ADDR_MASK;
      command[WORD_BITS-1] = req_is_read;
      command[WORD_BITS-4] = cfg.auto_increment;
   end

   assign in_next = {in_ff[WORD_BITS-2:0], line_ff[WORD_BITS-1]};
   assign drive   = phase_ff || !is_read_ff;
   assign sd      = drive ? out_ff[WORD_BITS-1] : level_ff;
   assign done    = !phase_ff && (cnt_ff == '0);

   always_comb begin
      open_in     = open_ff;
      is_read_in  = is_read_ff;
      phase_in    = phase_ff;
      level_in    = level_ff;
      slot_end_in = slot_end_ff;
      cnt_in      = cnt_ff;
      out_in      = out_ff;
      in_in       = in_ff;
      line_in     = line_ff;
      wdata_in    = wdata_ff;
      last_in     = last_ff;
      sd_in       = sd_ff;
      cph_in      = cph_ff;
      idx_in      = idx_ff;
      done_in     = done_ff;
      rword_in    = rword_ff;
      bend_in     = bend_ff;
      lst_in      = lst_ff;

      if (cmd.load_item) begin
         wdata_in    = WORD_BITS'(req_write_data);
         line_in     = WORD_BITS'(req_line_in_word);
         last_in     = req_last_word;
         cnt_in      = CNT_MAX;
         slot_end_in = 1'b0;
         if (!open_ff) begin
            open_in    = 1'b1;
            is_read_in = req_is_read;
            out_in     = command;
            phase_in   = 1'b1;
         end else begin
            phase_in = 1'b0;
            if (!is_read_ff) begin
               out_in = WORD_BITS'(req_write_data);
            end
         end
      end

      if (cmd.load_data) begin
         phase_in    = 1'b0;
         cnt_in      = CNT_MAX;
         slot_end_in = 1'b0;
         if (!is_read_ff) begin
            out_in = wdata_ff;
         end
      end

      if (cmd.shift_slot) begin
         sd_in       = sd;
         level_in    = sd;
         cph_in      = phase_ff;
         idx_in      = BIT_IDX_W'(cnt_ff);
         done_in     = done;
         rword_in    = (done && is_read_ff) ? FIELD_W'(in_next) : '0;
         bend_in     = done && last_ff;
         lst_in      = done;
         out_in      = {out_ff[WORD_BITS-2:0], 1'b0};
         slot_end_in = (cnt_ff == '0);
         cnt_in      = cnt_ff - CNT_W'(1);
         if (!phase_ff && is_read_ff) begin
            in_in   = in_next;
            line_in = {line_ff[WORD_BITS-2:0], 1'b0};
         end
         if (done && last_ff) begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         is_read_ff  <= 1'b0;
         phase_ff    <= 1'b0;
         level_ff    <= 1'b0;
         slot_end_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         open_ff     <= open_in;
         is_read_ff  <= is_read_in;
         phase_ff    <= phase_in;
         level_ff    <= level_in;
         slot_end_ff <= slot_end_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      in_ff    <= in_in;
      line_ff  <= line_in;
      wdata_ff <= wdata_in;
      last_ff  <= last_in;
      sd_ff    <= sd_in;
      cph_ff   <= cph_in;
      idx_ff   <= idx_in;
      done_ff  <= done_in;
      rword_ff <= rword_in;
      bend_ff  <= bend_in;
      lst_ff   <= lst_in;
   end

   assign status.burst_open = open_ff;
   assign status.is_read    = is_read_ff;
   assign status.cmd_phase  = phase_ff;
   assign status.slot_end   = slot_end_ff;

   assign rsp_sdout_bit     = sd_ff;
   assign rsp_command_phase = cph_ff;
   assign rsp_bit_index     = idx_ff;
   assign rsp_word_done     = done_ff;
   assign rsp_read_word     = rword_ff;
   assign rsp_burst_end     = bend_ff;
   assign rsp_last          = lst_ff;

   `SBM_ASSERT(a_close_on_burst_end, clock, reset, ($fell(open_ff) && !$past(reset)) |-> (bend_ff && lst_ff), "burst closed without end slot")

endmodule

### design/serial_register_bus_master.sv
//------------------------------------------------------------------------------
// Serial register bus master
// Four-wire serial register bus master moving bursts of 16-bit words.
//------------------------------------------------------------------------------
// Each request word is one word of a burst; the first word of a burst also
// sends the command word (read bit, auto-increment bit, address). One response
// word is returned per serial clock slot, with rsp_tlast on the final slot of
// the data word. Requests are taken one at a time. Each slot runs the
// serial clock period timer, then registers the slot and hands it off
// once rsp_tready is high, so an item takes WORD_BITS or 2 * WORD_BITS
// slots, then the write, read or select release gap before the next
// request is accepted.
module serial_register_bus_master
   import sbm_pkg::*;
#(
   parameter int WORD_BITS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [47:0]            req_tdata,   // address, write_data, line_in_word
   input  logic                   req_tuser,   // is_read
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // sdout_bit, bit_index, word_done,
                                               // read_word, burst_end
   output logic                   rsp_tuser,   // command_phase
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   sbm_cfg_type          cfg;
   sbm_cmd_type          cmd;
   sbm_status_type       status;
   logic                 sdout_bit;
   logic [BIT_IDX_W-1:0] bit_index;
   logic                 word_done;
   logic [FIELD_W-1:0]   read_word;
   logic                 burst_end;

   sbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sbm_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_is_read       (req_tuser),
      .req_address       (req_tdata[11:0]),
      .req_write_data    (req_tdata[27:12]),
      .req_line_in_word  (req_tdata[43:28]),
      .req_last_word     (req_tlast),
      .rsp_sdout_bit     (sdout_bit),
      .rsp_command_phase (rsp_tuser),
      .rsp_bit_index     (bit_index),
      .rsp_word_done     (word_done),
      .rsp_read_word     (read_word),
      .rsp_burst_end     (burst_end),
      .rsp_last          (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, burst_end, read_word, word_done, bit_index, sdout_bit};

endmodule
